// File: hdl/lpsd_pkg.sv
// Shared constants, state codes and the result type of the lidar sample decoder.
`default_nettype none

package lpsd_pkg;

	// Header bytes and frame layout.
	localparam logic [7:0] HDR_FIRST  = 8'hAA;
	localparam logic [7:0] HDR_SECOND = 8'h55;
	localparam int unsigned HEADER_LEN = 10;
	localparam logic [11:0] TOTAL_MAX = 12'hFFF;

	// Default configuration of the decoder.
	localparam int unsigned DEF_MAX_PACKET_SAMPLES = 40;
	localparam int unsigned DEF_SCAN_CAPACITY = 320;

	// Result kinds.
	localparam logic KIND_SAMPLE = 1'b0;
	localparam logic KIND_REPORT = 1'b1;

	// Framer phases, one-hot.
	typedef enum logic [4:0] {
		PH_HUNT  = 5'b00001,
		PH_SYNC  = 5'b00010,
		PH_TYPE  = 5'b00100,
		PH_COUNT = 5'b01000,
		PH_BODY  = 5'b10000
	} phase_t;

	// One result as it leaves the framer and waits in the output queue.
	typedef struct packed {
		logic        kind;
		logic [13:0] distance_mm;
		logic [8:0]  position;
		logic [11:0] scan_count;
	} result_t;

endpackage

`default_nettype wire

// File: hdl/lpsd_framer.sv
// Packet framer: header hunt, sample assembly and scan bookkeeping, one byte per cycle while take is high.
`default_nettype none

module lpsd_framer
	import lpsd_pkg::*;
#(
	parameter int unsigned MAX_PACKET_SAMPLES = DEF_MAX_PACKET_SAMPLES,
	parameter int unsigned SCAN_CAPACITY = DEF_SCAN_CAPACITY
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       take,
	input  wire logic [7:0] rx_byte,
	output      logic       res_valid,
	output      result_t    res
);

	phase_t      phase_q, phase_d;
	logic [6:0]  byte_index_q, byte_index_d;
	logic [5:0]  packet_samples_q, packet_samples_d;
	logic        start_packet_q, start_packet_d;
	logic [7:0]  low_byte_hold_q, low_byte_hold_d;
	logic [11:0] scan_total_q, scan_total_d;

	logic [6:0] next_index;
	logic [7:0] end_index;

	assign next_index = byte_index_q + 7'd1;
	assign end_index = 8'(HEADER_LEN) + {1'b0, packet_samples_q, 1'b0};

	// Next state and result for the byte in hand.
	always_comb begin
		phase_d = phase_q;
		byte_index_d = byte_index_q;
		packet_samples_d = packet_samples_q;
		start_packet_d = start_packet_q;
		low_byte_hold_d = low_byte_hold_q;
		scan_total_d = scan_total_q;
		res_valid = 1'b0;
		res = '0;

		unique case (phase_q)
			PH_HUNT: begin
				if (rx_byte == HDR_FIRST) begin
					byte_index_d = 7'd1;
					phase_d = PH_SYNC;
				end
			end
			PH_SYNC: begin
				if (rx_byte == HDR_SECOND) begin
					byte_index_d = 7'd2;
					phase_d = PH_TYPE;
				end else begin
					byte_index_d = '0;
					phase_d = PH_HUNT;
				end
			end
			PH_TYPE: begin
				start_packet_d = rx_byte[0];
				byte_index_d = 7'd3;
				phase_d = PH_COUNT;
			end
			PH_COUNT: begin
				// Oversized packets are abandoned.
				if (rx_byte > 8'(MAX_PACKET_SAMPLES)) begin
					byte_index_d = '0;
					phase_d = PH_HUNT;
				end else begin
					packet_samples_d = rx_byte[5:0];
					byte_index_d = 7'd4;
					phase_d = PH_BODY;
				end
			end
			PH_BODY: begin
				// Sample bytes: even offsets hold the low byte, odd offsets complete a sample.
				if (byte_index_q >= 7'(HEADER_LEN)) begin
					if (!byte_index_q[0]) begin
						low_byte_hold_d = rx_byte;
					end else if (!start_packet_q) begin
						if (scan_total_q < 12'(SCAN_CAPACITY)) begin
							res_valid = 1'b1;
							res.kind = KIND_SAMPLE;
							res.distance_mm = low_byte_hold_q[1] ? 14'd0
								: {rx_byte, low_byte_hold_q[7:2]};
							res.position = scan_total_q[8:0];
						end
						if (scan_total_q < TOTAL_MAX) begin
							scan_total_d = scan_total_q + 12'd1;
						end
					end
				end
				byte_index_d = next_index;
				// End of packet: a scan start packet reports and clears the count.
				if ({1'b0, next_index} == end_index) begin
					if (start_packet_q) begin
						res_valid = 1'b1;
						res.kind = KIND_REPORT;
						res.scan_count = scan_total_q;
						scan_total_d = '0;
					end
					byte_index_d = '0;
					phase_d = PH_HUNT;
				end
			end
			default: begin
				byte_index_d = '0;
				phase_d = PH_HUNT;
			end
		endcase
	end

	// State registers advance only on an accepted byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			byte_index_q <= '0;
			packet_samples_q <= '0;
			start_packet_q <= 1'b0;
			low_byte_hold_q <= '0;
			scan_total_q <= '0;
		end else if (take) begin
			phase_q <= phase_d;
			byte_index_q <= byte_index_d;
			packet_samples_q <= packet_samples_d;
			start_packet_q <= start_packet_d;
			low_byte_hold_q <= low_byte_hold_d;
			scan_total_q <= scan_total_d;
		end
	end

endmodule

`default_nettype wire

// File: hdl/lidar_packet_sample_decoder.sv
// Top level of the lidar packet sample decoder: framer and two-entry result queue.
`default_nettype none

// The decoder takes one serial byte per clock cycle while not stalled and
// produces at most one result per byte: a distance sample numbered by its
// scan position, or a report of the sample count when a scan start packet
// ends. The framer state updates in the same cycle the byte is accepted, and
// its result is registered into a two-entry output queue whose head drives
// the output side. Input stall rises only while both queue entries hold
// results that the consumer has not taken, so with a free-running consumer
// the block sustains one byte per cycle.
module lidar_packet_sample_decoder
	import lpsd_pkg::*;
#(
	parameter int unsigned MAX_PACKET_SAMPLES = DEF_MAX_PACKET_SAMPLES,
	parameter int unsigned SCAN_CAPACITY = DEF_SCAN_CAPACITY
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output      logic        in_stall,
	input  wire logic [7:0]  rx_byte,
	output      logic        out_valid,
	input  wire logic        out_stall,
	output      logic        kind,
	output      logic [13:0] distance_mm,
	output      logic [8:0]  position,
	output      logic [11:0] scan_count
);

	logic    take;
	logic    res_valid;
	result_t res;
	logic    push, pop;

	result_t    queue_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;

	assign in_stall = (count_q == 2'd2);
	assign take = in_valid && !in_stall;

	lpsd_framer #(
		.MAX_PACKET_SAMPLES(MAX_PACKET_SAMPLES),
		.SCAN_CAPACITY(SCAN_CAPACITY)
	) u_framer (
		.clk(clk),
		.arst_n(arst_n),
		.take(take),
		.rx_byte(rx_byte),
		.res_valid(res_valid),
		.res(res)
	);

	assign push = take && res_valid;
	assign pop = out_valid && !out_stall;

	// Result queue storage.
	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= res;
		end
	end

	// Queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	// Head of the queue drives the result ports.
	assign out_valid = (count_q != 2'd0);
	assign kind = queue_q[rd_ptr_q].kind;
	assign distance_mm = queue_q[rd_ptr_q].distance_mm;
	assign position = queue_q[rd_ptr_q].position;
	assign scan_count = queue_q[rd_ptr_q].scan_count;

endmodule

`default_nettype wire

// File: sim/tb_lidar_packet_sample_decoder.sv
// Self-checking testbench for the lidar packet sample decoder.
`default_nettype none

module tb_lidar_packet_sample_decoder
	import lpsd_pkg::*;
;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned MAX_SAMPLES = DEF_MAX_PACKET_SAMPLES;
	localparam int unsigned SCAN_CAP = DEF_SCAN_CAPACITY;
	localparam int RANDOM_ITEMS = 540;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int SETTLE_CYCLES = 16;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  rx_byte;
	logic        out_valid;
	logic        out_stall;
	logic        kind;
	logic [13:0] distance_mm;
	logic [8:0]  position;
	logic [11:0] scan_count;

	// Framer state mirrored by the testbench.
	phase_t      fr_phase = PH_HUNT;
	logic [6:0]  fr_index = '0;
	logic [5:0]  fr_samples = '0;
	logic        fr_scan_start = 1'b0;
	logic [7:0]  fr_low_byte = '0;
	logic [11:0] fr_scan_total = '0;

	result_t pending_results[$];
	int      mismatch_count = 0;
	int      bytes_sent = 0;
	int      burst_left = 0;
	bit      idle_on = 1'b1;
	bit      hold_off_request = 1'b0;

	lidar_packet_sample_decoder #(
		.MAX_PACKET_SAMPLES(MAX_SAMPLES),
		.SCAN_CAPACITY(SCAN_CAP)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.kind(kind),
		.distance_mm(distance_mm),
		.position(position),
		.scan_count(scan_count)
	);

	always #1 clk = ~clk;

	// Advance the mirrored framer by one accepted byte and queue what it produces.
	function automatic void track_frame_byte(input logic [7:0] b);
		result_t r;
		logic [6:0] p;
		logic [6:0] nxt;
		logic [6:0] off;
		case (fr_phase)
			PH_HUNT: begin
				if (b == HDR_FIRST) begin
					fr_index = 7'd1;
					fr_phase = PH_SYNC;
				end
			end
			PH_SYNC: begin
				// A wrong second header byte is dropped and the hunt restarts.
				if (b == HDR_SECOND) begin
					fr_index = 7'd2;
					fr_phase = PH_TYPE;
				end else begin
					fr_index = '0;
					fr_phase = PH_HUNT;
				end
			end
			PH_TYPE: begin
				fr_scan_start = b[0];
				fr_index = 7'd3;
				fr_phase = PH_COUNT;
			end
			PH_COUNT: begin
				// Oversized sample counts abandon the packet.
				if (b > MAX_SAMPLES) begin
					fr_index = '0;
					fr_phase = PH_HUNT;
				end else begin
					fr_samples = b[5:0];
					fr_index = 7'd4;
					fr_phase = PH_BODY;
				end
			end
			PH_BODY: begin
				p = fr_index;
				if (p >= HEADER_LEN) begin
					off = p - 7'(HEADER_LEN);
					if (!off[0]) begin
						fr_low_byte = b;
					end else if (!fr_scan_start) begin
						if (fr_scan_total < SCAN_CAP) begin
							r.kind = KIND_SAMPLE;
							r.distance_mm = fr_low_byte[1] ? 14'd0 : {b, fr_low_byte[7:2]};
							r.position = fr_scan_total[8:0];
							r.scan_count = 12'd0;
							pending_results.push_back(r);
						end
						if (fr_scan_total < TOTAL_MAX)
							fr_scan_total = fr_scan_total + 12'd1;
					end
				end
				nxt = p + 7'd1;
				fr_index = nxt;
				// End of packet: a scan start reports and clears the running count.
				if (nxt == HEADER_LEN + 2 * fr_samples) begin
					if (fr_scan_start) begin
						r.kind = KIND_REPORT;
						r.distance_mm = 14'd0;
						r.position = 9'd0;
						r.scan_count = fr_scan_total;
						pending_results.push_back(r);
						fr_scan_total = '0;
					end
					fr_index = '0;
					fr_phase = PH_HUNT;
				end
			end
			default: begin
				fr_index = '0;
				fr_phase = PH_HUNT;
			end
		endcase
	endfunction

	// Offer one byte request, idling between bursts when idle_on is set, and wait until it is accepted.
	task automatic send_byte(input logic [7:0] b);
		int gap;
		if (idle_on && burst_left == 0) begin
			gap = $urandom_range(1, 6);
			in_valid <= 1'b0;
			rx_byte <= 8'($urandom);
			repeat (gap) @(posedge clk);
			burst_left = $urandom_range(1, 24);
		end
		if (burst_left > 0)
			burst_left--;
		in_valid <= 1'b1;
		rx_byte <= b;
		do
			@(posedge clk);
		while (in_stall);
		track_frame_byte(b);
		bytes_sent++;
	endtask

	// Send a header with the given type and count, then body_bytes random bytes.
	task automatic send_packet(input logic [7:0] ptype, input logic [7:0] count,
			input int body_bytes);
		send_byte(HDR_FIRST);
		send_byte(HDR_SECOND);
		send_byte(ptype);
		send_byte(count);
		repeat (body_bytes) send_byte(8'($urandom));
	endtask

	// Header recovery, abandoned count, distance extremes and an empty scan start.
	task automatic test_directed_framing();
		logic [7:0] seq [0:29];
		seq = '{8'hAA, 8'h12,
			8'hAA, 8'h55, 8'h00, 8'h29,
			8'hAA, 8'h55, 8'hFE, 8'h02, 8'h11, 8'h22, 8'h33, 8'h44, 8'h00, 8'hFF,
			8'hFE, 8'hFF, 8'hFC, 8'hFF,
			8'hAA, 8'h55, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
		idle_on = 1'b1;
		foreach (seq[i]) send_byte(seq[i]);
	endtask

	// The receiver holds off for a long stretch while full packets keep coming.
	task automatic test_output_backpressure();
		idle_on = 1'b0;
		hold_off_request = 1'b1;
		repeat (2)
			send_packet(8'($urandom) & 8'hFE, 8'(MAX_SAMPLES), 6 + 2 * MAX_SAMPLES);
	endtask

	// Mostly well-formed packets with random content, mixed with broken framing.
	task automatic test_random_stream();
		int start_bytes;
		int choice;
		int count;
		logic [7:0] ptype;
		logic [7:0] bad;
		start_bytes = bytes_sent;
		while (bytes_sent - start_bytes < RANDOM_ITEMS) begin
			idle_on = ($urandom_range(0, 3) != 0);
			choice = $urandom_range(0, 99);
			ptype = 8'($urandom);
			ptype[0] = ($urandom_range(0, 4) == 0);
			count = ($urandom_range(0, 9) == 0) ? $urandom_range(0, MAX_SAMPLES)
				: $urandom_range(0, 8);
			if (choice < 70) begin
				send_packet(ptype, 8'(count), 6 + 2 * count);
			end else if (choice < 80) begin
				// Truncated packet: the following bytes land in its body.
				send_packet(ptype, 8'(count), $urandom_range(0, 5 + 2 * count));
			end else if (choice < 88) begin
				bad = 8'($urandom);
				if (bad == HDR_SECOND)
					bad = ~bad;
				send_byte(HDR_FIRST);
				send_byte(bad);
			end else if (choice < 94) begin
				send_packet(ptype, 8'($urandom_range(MAX_SAMPLES + 1, 255)), 0);
			end else begin
				repeat ($urandom_range(1, 8)) send_byte(8'($urandom));
			end
		end
	endtask

	// Receiver stall pattern: random segments of differing stall density.
	initial begin : receiver
		int seg_len;
		int stall_pct;
		out_stall = 1'b0;
		forever begin
			if (hold_off_request) begin
				hold_off_request = 1'b0;
				out_stall <= 1'b1;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
			end else begin
				seg_len = $urandom_range(1, 64);
				case ($urandom_range(0, 3))
					0: stall_pct = 0;
					1: stall_pct = 25;
					2: stall_pct = 60;
					default: stall_pct = 90;
				endcase
				for (int i = 0; i < seg_len && !hold_off_request; i++) begin
					out_stall <= ($urandom_range(0, 99) < stall_pct);
					@(posedge clk);
				end
			end
		end
	end

	// Compare every accepted result with the oldest expected one.
	always @(posedge clk) begin : result_check
		result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result: kind %0d distance_mm %0d position %0d scan_count %0d",
					kind, distance_mm, position, scan_count);
				mismatch_count++;
			end else begin
				want = pending_results.pop_front();
				if (kind !== want.kind) begin
					$error("kind: expected %0d, got %0d", want.kind, kind);
					mismatch_count++;
				end
				if (distance_mm !== want.distance_mm) begin
					$error("distance_mm: expected %0d, got %0d", want.distance_mm, distance_mm);
					mismatch_count++;
				end
				if (position !== want.position) begin
					$error("position: expected %0d, got %0d", want.position, position);
					mismatch_count++;
				end
				if (scan_count !== want.scan_count) begin
					$error("scan_count: expected %0d, got %0d", want.scan_count, scan_count);
					mismatch_count++;
				end
			end
		end
	end

	// Main sequence: reset, the tests in turn, then drain and report.
	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		rx_byte = 8'd0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_framing();
		test_output_backpressure();
		test_random_stream();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (pending_results.size() != 0) begin
			$error("%0d expected results never arrived", pending_results.size());
			mismatch_count++;
		end
		if (mismatch_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// Watchdog for a hung run.
	initial begin
		#400_000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule

`default_nettype wire
